@@ hdl/sdiv_pkg.sv @@
// ----------------------------------------------------------------------------
// sdiv_pkg
// Shared width and data types of the pipelined signed divider.
// ----------------------------------------------------------------------------
package sdiv_pkg;

  // operand and result width
  localparam int unsigned DATA_WIDTH = 32;

  // signed operand / result word
  typedef logic signed [DATA_WIDTH-1:0] sdata_t;

  // unsigned magnitude word
  typedef logic [DATA_WIDTH-1:0] udata_t;

  // most negative and most positive values, used on divide by zero
  localparam udata_t INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam udata_t INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

endpackage

@@ hdl/sdiv_in_if.sv @@
// ----------------------------------------------------------------------------
// sdiv_in_if
// Operand channel of the signed divider: valid/ready with dividend and divisor.
// ----------------------------------------------------------------------------
interface sdiv_in_if import sdiv_pkg::*;;

  logic   valid;
  logic   ready;
  sdata_t dividend;
  sdata_t divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);

endinterface

@@ hdl/sdiv_out_if.sv @@
// ----------------------------------------------------------------------------
// sdiv_out_if
// Result channel of the signed divider: valid/ready with quotient and remainder.
// ----------------------------------------------------------------------------
interface sdiv_out_if import sdiv_pkg::*;;

  logic   valid;
  logic   ready;
  sdata_t quotient;
  sdata_t remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);

endinterface

@@ hdl/signed_divide_with_remainder.sv @@
// ----------------------------------------------------------------------------
// signed_divide_with_remainder
// Pipelined signed divider with truncating quotient and remainder.
// ----------------------------------------------------------------------------
// Accepts one dividend/divisor pair per clock unless a stall has backed up to
// the input, and returns one result per pair, in order. One stage takes the
// operand magnitudes, DATA_WIDTH stages each resolve one quotient bit with a
// single restoring subtract, and the output register applies the signs. Each
// stage has its own valid bit and holds only while the stage after it is full
// and stalled, so bubbles close up and input keeps flowing while a result waits.
// The quotient truncates toward zero and the remainder takes the dividend's
// sign. Divide by zero gives remainder 0 and quotient INT_MIN for a negative
// dividend, INT_MAX otherwise; INT_MIN / -1 wraps to INT_MIN. No flags.
// ----------------------------------------------------------------------------
module signed_divide_with_remainder import sdiv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sdiv_in_if.sink     in_ch,
  sdiv_out_if.source  out_ch
);

  localparam int unsigned NSTG = DATA_WIDTH + 1;

  // per-stage pipeline registers, stage 0 holds magnitudes
  logic   v_r     [NSTG];
  udata_t rem_r   [NSTG];
  udata_t quo_r   [NSTG];
  udata_t mb_r    [NSTG];
  logic   a_neg_r [NSTG];
  logic   q_neg_r [NSTG];
  logic   dz_r    [NSTG];

  // stage advance enables, last entry is the output register
  logic   rdy [NSTG+1];

  // output register
  logic   out_valid_r;
  udata_t out_q_r;
  udata_t out_r_r;

  // operand decode
  udata_t a_in;
  udata_t b_in;
  logic   a_neg;
  logic   b_neg;
  udata_t ma;
  udata_t mb;

  assign a_in  = udata_t'(in_ch.dividend);
  assign b_in  = udata_t'(in_ch.divisor);
  assign a_neg = a_in[DATA_WIDTH-1];
  assign b_neg = b_in[DATA_WIDTH-1];
  assign ma    = a_neg ? (~a_in + udata_t'(1)) : a_in;
  assign mb    = b_neg ? (~b_in + udata_t'(1)) : b_in;

  // ready chain: a stage may load when empty or when it is moving on
  assign rdy[NSTG]   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = rdy[0];

  genvar gi;
  generate
    for (gi = 0; gi < NSTG; gi++) begin : g_rdy
      assign rdy[gi] = !v_r[gi] || rdy[gi+1];
    end
  endgenerate

  // magnitude stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_r[0] <= in_ch.valid;
    end
    if (rdy[0] && in_ch.valid) begin
      rem_r[0]   <= '0;
      quo_r[0]   <= ma;
      mb_r[0]    <= mb;
      a_neg_r[0] <= a_neg;
      q_neg_r[0] <= a_neg ^ b_neg;
      dz_r[0]    <= (b_in == '0);
    end
  end

  // restoring divide stages, one quotient bit each
  generate
    for (gi = 1; gi < NSTG; gi++) begin : g_div
      logic [DATA_WIDTH:0] shifted;
      logic [DATA_WIDTH:0] diff;
      logic                take;

      assign shifted = {rem_r[gi-1], quo_r[gi-1][DATA_WIDTH-1]};
      assign diff    = shifted - {1'b0, mb_r[gi-1]};
      assign take    = !diff[DATA_WIDTH];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[gi] <= 1'b0;
        end else if (rdy[gi]) begin
          v_r[gi] <= v_r[gi-1];
        end
        if (rdy[gi] && v_r[gi-1]) begin
          rem_r[gi]   <= take ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
          quo_r[gi]   <= {quo_r[gi-1][DATA_WIDTH-2:0], take};
          mb_r[gi]    <= mb_r[gi-1];
          a_neg_r[gi] <= a_neg_r[gi-1];
          q_neg_r[gi] <= q_neg_r[gi-1];
          dz_r[gi]    <= dz_r[gi-1];
        end
      end
    end
  endgenerate

  // sign fix and divide-by-zero override
  udata_t q_fix;
  udata_t r_fix;

  always_comb begin
    if (dz_r[NSTG-1]) begin
      q_fix = a_neg_r[NSTG-1] ? INT_MIN : INT_MAX;
      r_fix = '0;
    end else begin
      q_fix = q_neg_r[NSTG-1] ? (~quo_r[NSTG-1] + udata_t'(1)) : quo_r[NSTG-1];
      r_fix = a_neg_r[NSTG-1] ? (~rem_r[NSTG-1] + udata_t'(1)) : rem_r[NSTG-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[NSTG]) begin
      out_valid_r <= v_r[NSTG-1];
    end
    if (rdy[NSTG] && v_r[NSTG-1]) begin
      out_q_r <= q_fix;
      out_r_r <= r_fix;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.quotient  = sdata_t'(out_q_r);
  assign out_ch.remainder = sdata_t'(out_r_r);

endmodule

@@ bench/sdiv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdiv_checker
// Watches both channels of the signed divider and scores every result.
// ----------------------------------------------------------------------------
// Each operand transfer is turned into its expected quotient and remainder,
// held in arrival order. Each result transfer is compared field by field with
// the oldest expectation. The number of open expectations and the number of
// mismatches are handed to the testbench top.
// ----------------------------------------------------------------------------
module sdiv_checker import sdiv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sdiv_in_if          in_ch,
  sdiv_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    sdata_t quotient;
    sdata_t remainder;
  } div_result_t;

  // expected results, oldest first
  div_result_t expected_results[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // truncating signed division on magnitudes, signs applied afterwards
  function automatic div_result_t divide_truncating(sdata_t num, sdata_t den);
    div_result_t res;
    udata_t      num_mag;
    udata_t      den_mag;
    udata_t      quo_mag;
    udata_t      rem_mag;
    logic        num_neg;
    logic        den_neg;
    num_neg = num[DATA_WIDTH-1];
    den_neg = den[DATA_WIDTH-1];
    if (den == '0) begin
      // divide by zero saturates toward the dividend's sign
      res.quotient  = num_neg ? sdata_t'(INT_MIN) : sdata_t'(INT_MAX);
      res.remainder = '0;
    end else begin
      // most negative value has magnitude 2^(w-1), exact in unsigned
      num_mag = num_neg ? udata_t'(-num) : udata_t'(num);
      den_mag = den_neg ? udata_t'(-den) : udata_t'(den);
      quo_mag = num_mag / den_mag;
      rem_mag = num_mag % den_mag;
      res.quotient  = (num_neg != den_neg) ? sdata_t'(-quo_mag) : sdata_t'(quo_mag);
      res.remainder = num_neg ? sdata_t'(-rem_mag) : sdata_t'(rem_mag);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input sdata_t got, input sdata_t want);
    $display("%0t: %s: got %0d (0x%h), expected %0d (0x%h)",
             $realtime, what, got, got, want, want);
    fail_count++;
  endtask

  // score result transfers, then record operand transfers
  always @(posedge clk) begin
    div_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing expected", out_ch.quotient, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.quotient !== want.quotient)
            report_mismatch("quotient", out_ch.quotient, want.quotient);
          if (out_ch.remainder !== want.remainder)
            report_mismatch("remainder", out_ch.remainder, want.remainder);
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(divide_truncating(in_ch.dividend, in_ch.divisor));
    end
    pending <= expected_results.size();
  end

endmodule

@@ bench/signed_divide_with_remainder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_divide_with_remainder_tb
// Stimulus and verdict for the pipelined signed divider.
// ----------------------------------------------------------------------------
// Drives directed corner pairs (zero divisor, most negative dividend, minus
// one, sign mixes) and then random pairs in three phases of sender and
// receiver idling, with one long receiver stall that backs up the pipeline.
// Scoring is done by sdiv_checker; this module only reports its outcome.
// ----------------------------------------------------------------------------
module signed_divide_with_remainder_tb;
  import sdiv_pkg::*;

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold_cycles;
  int unsigned fail_count;
  int unsigned pending;

  sdiv_in_if  in_ch ();
  sdiv_out_if out_ch ();

  signed_divide_with_remainder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sdiv_checker div_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("signed_divide_with_remainder test failed");
    $finish;
  end

  // result side: random stalls, or a counted hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        recv_hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // offer one pair, with random idle cycles first; returns on the falling
  // edge after the transfer, leaving valid for the caller to drive next
  task automatic send_pair(input sdata_t num, input sdata_t den);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= num;
    in_ch.divisor  <= den;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // operand biased toward small values and the two extremes
  function automatic sdata_t rand_operand();
    sdata_t val;
    case ($urandom_range(5))
      0:       val = sdata_t'($urandom_range(15));
      1:       val = -sdata_t'($urandom_range(15));
      2:       val = sdata_t'(INT_MIN) + sdata_t'($urandom_range(3));
      3:       val = sdata_t'(INT_MAX) - sdata_t'($urandom_range(3));
      default: val = sdata_t'($urandom());
    endcase
    return val;
  endfunction

  task automatic send_random(input int unsigned count);
    sdata_t num;
    sdata_t den;
    repeat (count) begin
      num = rand_operand();
      den = rand_operand();
      case ($urandom_range(15))
        0: den = '0;
        1: den = $urandom_range(1) ? sdata_t'(1) : sdata_t'(-1);
        // exact multiple, remainder zero unless the product wraps
        2: num = den * sdata_t'($urandom_range(9));
        // short divisor against a wide dividend
        3: begin
          num = sdata_t'($urandom());
          den = sdata_t'($urandom_range(1, 255));
          if ($urandom_range(1)) den = -den;
        end
        default: ;
      endcase
      send_pair(num, den);
    end
  endtask

  // stop offering and wait until every result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // reset and stimulus
  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.dividend   = '0;
    in_ch.divisor    = '0;
    send_idle_pct    = 30;
    recv_idle_pct    = 80;
    recv_hold_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // divide by zero for each dividend sign
    send_pair(0, 0);
    send_pair(5, 0);
    send_pair(-5, 0);
    send_pair(sdata_t'(INT_MIN), 0);
    send_pair(sdata_t'(INT_MAX), 0);
    // most negative dividend, including the wrapping case
    send_pair(sdata_t'(INT_MIN), -1);
    send_pair(sdata_t'(INT_MIN), 1);
    send_pair(sdata_t'(INT_MIN), sdata_t'(INT_MIN));
    send_pair(sdata_t'(INT_MIN), sdata_t'(INT_MAX));
    send_pair(sdata_t'(INT_MAX), sdata_t'(INT_MIN));
    send_pair(sdata_t'(INT_MAX), -1);
    send_pair(sdata_t'(INT_MAX), sdata_t'(INT_MAX));
    // all four sign combinations with a nonzero remainder
    send_pair(7, 2);
    send_pair(-7, 2);
    send_pair(7, -2);
    send_pair(-7, -2);
    send_pair(100, 7);
    send_pair(-100, -7);
    // divisor at least as large in magnitude as the dividend
    send_pair(1, sdata_t'(INT_MAX));
    send_pair(-1, sdata_t'(INT_MIN));
    send_pair(0, -1);
    send_pair(-1, -1);
    send_pair(sdata_t'(32'hffff_ffff), sdata_t'(32'h0000_ffff));

    // phase one: sender idles a little, receiver a lot, with a long stall
    send_random(250);
    recv_hold_cycles = 300;
    send_random(300);
    drain_results();

    // phase two: roles swapped
    send_idle_pct = 80;
    recv_idle_pct = 30;
    send_random(560);
    drain_results();

    // phase three: full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(580);
    drain_results();

    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("signed_divide_with_remainder test passed");
    end else begin
      $display("signed_divide_with_remainder test failed");
    end
    $finish;
  end

endmodule

@@ signed_divide_with_remainder.f @@
hdl/sdiv_pkg.sv
hdl/sdiv_in_if.sv
hdl/sdiv_out_if.sv
hdl/signed_divide_with_remainder.sv
bench/sdiv_checker.sv
bench/signed_divide_with_remainder_tb.sv
